// ----- sv/bmmp_pkg.sv -----
// ----------------------------------------------------------------------------
// bmmp_pkg
// shared widths, output codes and tag codes of the boot memory map parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmmp_pkg;

  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 64;
  localparam int TYPE_W   = 32;
  localparam int IDX_W    = 7;
  localparam int REASON_W = 3;

  // result kind
  localparam logic KIND_REGION = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  // stop reasons on the finished marker
  localparam logic [REASON_W-1:0] STOP_END_TAG    = 3'd0;
  localparam logic [REASON_W-1:0] STOP_MAP_DONE   = 3'd1;
  localparam logic [REASON_W-1:0] STOP_SIZE_EXH   = 3'd2;
  localparam logic [REASON_W-1:0] STOP_STORE_FULL = 3'd3;
  localparam logic [REASON_W-1:0] STOP_BAD_ESIZE  = 3'd4;

  // tag types
  localparam logic [WORD_W-1:0] TAG_END  = 32'd0;
  localparam logic [WORD_W-1:0] TAG_MMAP = 32'd6;

  // byte counts of fixed structure parts
  localparam logic [WORD_W-1:0] WORD_BYTES      = 32'd4;
  localparam logic [WORD_W-1:0] TAG_HDR_BYTES   = 32'd8;
  localparam logic [WORD_W-1:0] MIN_ENTRY_BYTES = 32'd20;

endpackage

`default_nettype wire

// ----- sv/bmmp_stream_if.sv -----
// ----------------------------------------------------------------------------
// bmmp stream interfaces
// valid/ready channels for structure words in and parsed results out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bmmp_in_if;
  logic                       valid;
  logic                       ready;
  logic [bmmp_pkg::WORD_W-1:0] word;
  logic                       first;

  modport source (output valid, output word, output first, input ready);
  modport sink   (input valid, input word, input first, output ready);
endinterface

interface bmmp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bmmp_pkg::ADDR_W-1:0]   base;
  logic [bmmp_pkg::ADDR_W-1:0]   length;
  logic [bmmp_pkg::TYPE_W-1:0]   region_type;
  logic [bmmp_pkg::IDX_W-1:0]    region_index;
  logic [bmmp_pkg::REASON_W-1:0] stop_reason;

  modport source (output valid, output kind, output base, output length,
                  output region_type, output region_index, output stop_reason,
                  input ready);
  modport sink   (input valid, input kind, input base, input length,
                  input region_type, input region_index, input stop_reason,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/bmmp_pad_calc.sv -----
// ----------------------------------------------------------------------------
// bmmp_pad_calc
// skip length of a tag body: size padded to the tag alignment, less the
// tag header, rounded up to whole words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmmp_pad_calc #(
  parameter int TAG_ALIGN_BYTES = 8
) (
  input  wire logic [bmmp_pkg::WORD_W-1:0] tag_size,
  output logic [bmmp_pkg::WORD_W+1:0]      skip_bytes
);

  localparam int RW = $clog2(TAG_ALIGN_BYTES);
  localparam int M1 = 256 % TAG_ALIGN_BYTES;
  localparam int M2 = 65536 % TAG_ALIGN_BYTES;
  localparam int M3 = 16777216 % TAG_ALIGN_BYTES;

  typedef logic [RW-1:0] rem_tbl_t [256];

  // residue of (byte value * weight) modulo the alignment
  function automatic rem_tbl_t build_tbl(input int mul);
    rem_tbl_t t;
    int       e;
    for (e = 0; e < 256; e++) begin
      t[e] = RW'((e * mul) % TAG_ALIGN_BYTES);
    end
    return t;
  endfunction

  localparam rem_tbl_t TBL0 = build_tbl(1);
  localparam rem_tbl_t TBL1 = build_tbl(M1);
  localparam rem_tbl_t TBL2 = build_tbl(M2);
  localparam rem_tbl_t TBL3 = build_tbl(M3);

  logic [7:0]                      rem_sum;
  logic [RW-1:0]                   rem;
  logic [6:0]                      pad_add;
  logic [bmmp_pkg::WORD_W:0]       padded;
  logic [bmmp_pkg::WORD_W:0]       padded_min;
  logic [bmmp_pkg::WORD_W:0]       body;

  always_comb begin
    rem_sum = 8'(TBL0[tag_size[7:0]]) + 8'(TBL1[tag_size[15:8]])
            + 8'(TBL2[tag_size[23:16]]) + 8'(TBL3[tag_size[31:24]]);
    rem     = TBL0[rem_sum];
    pad_add = (rem == '0) ? 7'd0 : (7'(TAG_ALIGN_BYTES) - 7'(rem));
    padded  = {1'b0, tag_size} + 33'(pad_add);
    // a padded size below the header still moves on by one header
    padded_min = (padded < 33'(bmmp_pkg::TAG_HDR_BYTES)) ?
                 33'(bmmp_pkg::TAG_HDR_BYTES) : padded;
    body       = padded_min - 33'(bmmp_pkg::TAG_HDR_BYTES);
    skip_bytes = (34'(body) + 34'd3) & ~34'd3;
  end

endmodule

`default_nettype wire

// ----- sv/boot_memory_map_parser_top.sv -----
// ----------------------------------------------------------------------------
// boot_memory_map_parser_top
// walks a boot information structure word by word and reports the regions
// of its memory-map tag, closed by a finished marker
// ----------------------------------------------------------------------------
// usage
//   in_chan  : one 32-bit little-endian structure word per handshake; first
//              marks the total-size header word and restarts any parse
//   out_chan : region records (kind 0) and one finished marker (kind 1) that
//              carries the region count and the stop reason
//   a word is taken into an input register, processed from there by the parse
//   state machine once the output register is free or being taken, and its
//   result, if any, lands in the output register
//   throughput is one word per cycle while results are taken; the output
//   register parts the two sides, so a word is taken while a result waits
//   as long as that result is taken in the same cycle the next is written
//   when the receiver stalls, the word in the input register waits and
//   in_chan.ready drops once that register is full
//   after the word that emits the last region, the marker follows with the
//   next word accepted
//   reset (rst_n low, synchronous) empties both registers and leaves the
//   parser idle; words without first are ignored until a header arrives
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boot_memory_map_parser_top #(
  parameter int MAX_REGIONS     = 64,
  parameter int TAG_ALIGN_BYTES = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bmmp_in_if.sink    in_chan,
  bmmp_out_if.source out_chan
);

  localparam int W    = bmmp_pkg::WORD_W;
  localparam int RC_W = $clog2(MAX_REGIONS + 1);
  localparam int EW_W = W - 1;   // entry length in words

  // parse phases
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RSVD      = 4'd1;
  localparam logic [3:0] PH_TAG_TYPE  = 4'd2;
  localparam logic [3:0] PH_TAG_SIZE  = 4'd3;
  localparam logic [3:0] PH_SKIP      = 4'd4;
  localparam logic [3:0] PH_MAP_ESIZE = 4'd5;
  localparam logic [3:0] PH_MAP_VER   = 4'd6;
  localparam logic [3:0] PH_ENTRY     = 4'd7;
  localparam logic [3:0] PH_FINISH    = 4'd8;
  localparam logic [3:0] PH_DONE      = 4'd9;

  // word positions inside a map entry
  localparam logic [EW_W-1:0] ENT_BASE_LO = 31'd0;
  localparam logic [EW_W-1:0] ENT_BASE_HI = 31'd1;
  localparam logic [EW_W-1:0] ENT_LEN_LO  = 31'd2;
  localparam logic [EW_W-1:0] ENT_LEN_HI  = 31'd3;
  localparam logic [EW_W-1:0] ENT_TYPE    = 31'd4;

  // saturating step down by one word
  function automatic logic [W-1:0] less4(input logic [W-1:0] x);
    return (x >= bmmp_pkg::WORD_BYTES) ? (x - bmmp_pkg::WORD_BYTES) : '0;
  endfunction

  // input register
  logic         in_valid_r;
  logic [W-1:0] in_word_r;
  logic         in_first_r;
  logic         in_take;
  logic         adv;

  // parse state
  logic [3:0]                      phase_r, phase_nxt;
  logic [W-1:0]                    struct_left_r, struct_left_nxt;
  logic [W-1:0]                    tag_left_r, tag_left_nxt;
  logic                            is_mmap_r, is_mmap_nxt;
  logic [EW_W-1:0]                 esz_w_r, esz_w_nxt;
  logic [EW_W-1:0]                 pos_r, pos_nxt;
  logic [bmmp_pkg::ADDR_W-1:0]     base_r, base_nxt;
  logic [bmmp_pkg::ADDR_W-1:0]     len_r, len_nxt;
  logic [RC_W-1:0]                 regions_r, regions_nxt;
  logic [bmmp_pkg::REASON_W-1:0]   pend_r, pend_nxt;

  // output register
  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [bmmp_pkg::ADDR_W-1:0]     out_base_r;
  logic [bmmp_pkg::ADDR_W-1:0]     out_len_r;
  logic [bmmp_pkg::TYPE_W-1:0]     out_type_r;
  logic [bmmp_pkg::IDX_W-1:0]      out_idx_r;
  logic [bmmp_pkg::REASON_W-1:0]   out_reason_r;

  // step results
  logic                            emit_region;
  logic                            do_finish;
  logic [bmmp_pkg::REASON_W-1:0]   fin_reason;
  logic                            want_entry;
  logic                            entry_emitted;
  logic [W-1:0]                    sl;
  logic [W-1:0]                    tl;
  logic [W+1:0]                    skip_bytes;
  logic                            fits;
  logic [bmmp_pkg::REASON_W-1:0]   ne_reason;

  bmmp_pad_calc #(
    .TAG_ALIGN_BYTES (TAG_ALIGN_BYTES)
  ) u_pad_calc (
    .tag_size   (in_word_r),
    .skip_bytes (skip_bytes)
  );

  // handshakes: the input register moves on when the output slot is free
  assign adv           = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r  <= in_chan.word;
      in_first_r <= in_chan.first;
    end
  end

  // one parse step on the registered word
  always_comb begin
    phase_nxt       = phase_r;
    struct_left_nxt = struct_left_r;
    tag_left_nxt    = tag_left_r;
    is_mmap_nxt     = is_mmap_r;
    esz_w_nxt       = esz_w_r;
    pos_nxt         = pos_r;
    base_nxt        = base_r;
    len_nxt         = len_r;
    regions_nxt     = regions_r;
    pend_nxt        = pend_r;
    emit_region     = 1'b0;
    do_finish       = 1'b0;
    fin_reason      = bmmp_pkg::STOP_END_TAG;
    want_entry      = 1'b0;
    entry_emitted   = 1'b0;
    sl              = less4(struct_left_r);
    tl              = less4(tag_left_r);
    fits            = 1'b0;
    ne_reason       = bmmp_pkg::STOP_MAP_DONE;

    // marker held back from the step that emitted the last region
    if (phase_r == PH_FINISH) begin
      do_finish  = 1'b1;
      fin_reason = pend_r;
      phase_nxt  = PH_DONE;
    end

    if (in_first_r) begin
      // header word: drop any parse in flight and start over
      phase_nxt       = PH_RSVD;
      struct_left_nxt = less4(in_word_r);
      regions_nxt     = '0;
    end else if (phase_r != PH_IDLE && phase_r != PH_DONE && phase_r != PH_FINISH) begin
      struct_left_nxt = sl;
      unique case (phase_r)
        PH_RSVD: begin
          if (sl < bmmp_pkg::TAG_HDR_BYTES) begin
            do_finish  = 1'b1;
            fin_reason = bmmp_pkg::STOP_SIZE_EXH;
          end else begin
            phase_nxt = PH_TAG_TYPE;
          end
        end
        PH_TAG_TYPE: begin
          is_mmap_nxt = (in_word_r == bmmp_pkg::TAG_MMAP);
          if (in_word_r == bmmp_pkg::TAG_END) begin
            do_finish  = 1'b1;
            fin_reason = bmmp_pkg::STOP_END_TAG;
          end else begin
            phase_nxt = PH_TAG_SIZE;
          end
        end
        PH_TAG_SIZE: begin
          if (is_mmap_r) begin
            tag_left_nxt = (in_word_r >= bmmp_pkg::TAG_HDR_BYTES) ?
                           (in_word_r - bmmp_pkg::TAG_HDR_BYTES) : '0;
            phase_nxt    = PH_MAP_ESIZE;
          end else if (35'(sl) < (35'(skip_bytes) + 35'(bmmp_pkg::TAG_HDR_BYTES))) begin
            do_finish  = 1'b1;
            fin_reason = bmmp_pkg::STOP_SIZE_EXH;
          end else if (skip_bytes == '0) begin
            // empty body: straight on to the next tag boundary
            if (sl < bmmp_pkg::TAG_HDR_BYTES) begin
              do_finish  = 1'b1;
              fin_reason = bmmp_pkg::STOP_SIZE_EXH;
            end else begin
              phase_nxt = PH_TAG_TYPE;
            end
          end else begin
            tag_left_nxt = skip_bytes[W-1:0];
            phase_nxt    = PH_SKIP;
          end
        end
        PH_SKIP: begin
          tag_left_nxt = tl;
          if (tl == '0) begin
            if (sl < bmmp_pkg::TAG_HDR_BYTES) begin
              do_finish  = 1'b1;
              fin_reason = bmmp_pkg::STOP_SIZE_EXH;
            end else begin
              phase_nxt = PH_TAG_TYPE;
            end
          end
        end
        PH_MAP_ESIZE: begin
          esz_w_nxt    = EW_W'(({1'b0, in_word_r} + 33'd3) >> 2);
          tag_left_nxt = tl;
          if (in_word_r < bmmp_pkg::MIN_ENTRY_BYTES) begin
            do_finish  = 1'b1;
            fin_reason = bmmp_pkg::STOP_BAD_ESIZE;
          end else begin
            phase_nxt = PH_MAP_VER;
          end
        end
        PH_MAP_VER: begin
          tag_left_nxt = tl;
          want_entry   = 1'b1;
        end
        PH_ENTRY: begin
          tag_left_nxt = tl;
          unique case (pos_r)
            ENT_BASE_LO: base_nxt = {32'd0, in_word_r};
            ENT_BASE_HI: base_nxt = {in_word_r, base_r[31:0]};
            ENT_LEN_LO:  len_nxt  = {32'd0, in_word_r};
            ENT_LEN_HI:  len_nxt  = {in_word_r, len_r[31:0]};
            ENT_TYPE: begin
              if (len_r != '0) begin
                emit_region   = 1'b1;
                entry_emitted = 1'b1;
                regions_nxt   = regions_r + RC_W'(1);
              end
            end
            default: ;  // padding bytes past the type word
          endcase
          if ((pos_r + EW_W'(1)) >= esz_w_r) begin
            want_entry = 1'b1;
          end else begin
            pos_nxt = pos_r + EW_W'(1);
          end
        end
        default: ;
      endcase

      // another entry, or the end of the map
      if (want_entry) begin
        fits = {1'b0, tl} >= {esz_w_r, 2'b00};
        if (fits && (regions_nxt < RC_W'(MAX_REGIONS))) begin
          phase_nxt = PH_ENTRY;
          pos_nxt   = '0;
        end else begin
          ne_reason = fits ? bmmp_pkg::STOP_STORE_FULL : bmmp_pkg::STOP_MAP_DONE;
          if (entry_emitted) begin
            pend_nxt  = ne_reason;
            phase_nxt = PH_FINISH;
          end else begin
            do_finish  = 1'b1;
            fin_reason = ne_reason;
          end
        end
      end

      if (do_finish) begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      regions_r <= '0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      regions_r <= regions_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      struct_left_r <= struct_left_nxt;
      tag_left_r    <= tag_left_nxt;
      is_mmap_r     <= is_mmap_nxt;
      esz_w_r       <= esz_w_nxt;
      pos_r         <= pos_nxt;
      base_r        <= base_nxt;
      len_r         <= len_nxt;
      pend_r        <= pend_nxt;
    end
  end

  // output register: loaded on a step with a result, cleared when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit_region || do_finish;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (do_finish) begin
        out_kind_r   <= bmmp_pkg::KIND_DONE;
        out_base_r   <= '0;
        out_len_r    <= '0;
        out_type_r   <= '0;
        out_idx_r    <= bmmp_pkg::IDX_W'(regions_r);
        out_reason_r <= fin_reason;
      end else if (emit_region) begin
        out_kind_r   <= bmmp_pkg::KIND_REGION;
        out_base_r   <= base_r;
        out_len_r    <= len_r;
        out_type_r   <= in_word_r;
        out_idx_r    <= bmmp_pkg::IDX_W'(regions_r);
        out_reason_r <= bmmp_pkg::STOP_END_TAG;
      end
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.base         = out_base_r;
  assign out_chan.length       = out_len_r;
  assign out_chan.region_type  = out_type_r;
  assign out_chan.region_index = out_idx_r;
  assign out_chan.stop_reason  = out_reason_r;

endmodule

`default_nettype wire
